>>> hdl/heap_kth_smallest_select_top_macros.svh
// Assertion macros for the heap k-th smallest selector.
// Used by heap_kth_smallest_select_top; expects clk and arst_n in scope.
`ifndef HEAP_KTH_SMALLEST_SELECT_TOP_MACROS_SVH
`define HEAP_KTH_SMALLEST_SELECT_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HKS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define HKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/hks_pkg.sv
// Shared types and constants for the heap k-th smallest selector.
// No dependencies.
package hks_pkg;
	localparam int VALUE_W  = 32;
	localparam int RANK_W   = 11;
	localparam int STATUS_W = 2;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [RANK_W-1:0]         rank_t;
	typedef logic [STATUS_W-1:0]       status_t;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_RANK = 2'd1;
	localparam status_t ST_OVF  = 2'd2;
endpackage

>>> hdl/hks_item_if.sv
// Request channel carrying one set element, its rank and the last marker.
// Depends on hks_pkg.
interface hks_item_if import hks_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value;
	rank_t  rank;
	logic   last;

	modport source (output valid, value, rank, last, input ready);
	modport sink (input valid, value, rank, last, output ready);
endinterface

>>> hdl/hks_result_if.sv
// Result channel carrying the selected value and its status.
// Depends on hks_pkg.
interface hks_result_if import hks_pkg::*; ();
	logic    valid;
	logic    ready;
	value_t  kth_value;
	status_t status;

	modport source (output valid, kth_value, status, input ready);
	modport sink (input valid, kth_value, status, output ready);
endinterface

>>> hdl/hks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hdl/heap_kth_smallest_select_top.sv
// Heap-select k-th smallest value over a set of signed 32-bit requests.
// Depends on hks_pkg, hks_item_if, hks_result_if, hks_ram and the macros header.
//
// channel  dir  payload                 handshake
// item     in   value, rank, last       valid/ready
// result   out  kth_value, status       valid/ready
//
// Loading takes one cycle per request; ready stays high while the set streams in.
// On the last request the shared compare unit runs sift-downs over the value RAM
// (n/2 sifts) and then k-1 or n-k candidate pops, each a sift-down plus up to
// two sift-up inserts in the candidate RAM; ready is low.
// The finished result sits in an output register; a stalled result holds the
// block before it returns to loading. Reset clears all counts; no RAM clearing.
`include "heap_kth_smallest_select_top_macros.svh"

module heap_kth_smallest_select_top import hks_pkg::*; #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	hks_item_if.sink     item,
	hks_result_if.source result
);
	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int IW  = AW + 2;
	localparam int KW  = (CW > RANK_W ? CW : RANK_W) + 1;
	localparam int CDW = VALUE_W + AW;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_BLD    = 5'd1;
	localparam logic [4:0] S_SDLOAD = 5'd2;
	localparam logic [4:0] S_SDDOWN = 5'd3;
	localparam logic [4:0] S_SDL    = 5'd4;
	localparam logic [4:0] S_SDR    = 5'd5;
	localparam logic [4:0] S_SDMV   = 5'd6;
	localparam logic [4:0] S_SDFIN  = 5'd7;
	localparam logic [4:0] S_CINIT  = 5'd8;
	localparam logic [4:0] S_CINS   = 5'd9;
	localparam logic [4:0] S_INUP   = 5'd10;
	localparam logic [4:0] S_INCMP  = 5'd11;
	localparam logic [4:0] S_PLOOP  = 5'd12;
	localparam logic [4:0] S_PTOP   = 5'd13;
	localparam logic [4:0] S_PLAST  = 5'd14;
	localparam logic [4:0] S_PCH    = 5'd15;
	localparam logic [4:0] S_PINSL  = 5'd16;
	localparam logic [4:0] S_PRIGHT = 5'd17;
	localparam logic [4:0] S_PINSR  = 5'd18;
	localparam logic [4:0] S_PEND   = 5'd19;
	localparam logic [4:0] S_RES    = 5'd20;
	localparam logic [4:0] S_RES2   = 5'd21;
	localparam logic [4:0] S_FIN    = 5'd22;

	logic [4:0]     state_q, ret_q;
	logic [CW-1:0]  cnt_q, ccount_q, pops_q, bi_q;
	logic           ovf_q, mode_q, hsel_q;
	logic [AW-1:0]  si_q, best_q, c_q, pp_q, pt_q;
	logic [CDW-1:0] t_q, bv_q, ins_q;
	value_t         res_q;
	status_t        st_q;
	logic           out_valid_q;
	value_t         out_kth_q;
	status_t        out_st_q;

	// RAM ports
	logic           s_we, c_we;
	logic [AW-1:0]  s_wa, s_ra, c_wa, c_ra;
	value_t         s_wd, s_rd;
	logic [CDW-1:0] c_wd, c_rd;

	hks_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_value_ram (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
	);
	hks_ram #(.WIDTH(CDW), .DEPTH(MAX_ITEMS)) u_cand_ram (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
	);

	// helper values
	logic           fire, fits, ovf_new, rank_bad, fin_go;
	logic [CW-1:0]  n_new, hn;
	logic [IW-1:0]  lx, rx, plx, prx, hn_x, n_x;
	logic [CDW-1:0] hrd;
	logic [AW-1:0]  bi_m1, cc_m1;
	value_t         cmp_a, cmp_b;
	logic           gf;
	logic [KW-1:0]  k_x, n_k;

	assign fire     = item.valid && item.ready;
	assign fits     = cnt_q < CW'(MAX_ITEMS);
	assign n_new    = fits ? cnt_q + CW'(1) : cnt_q;
	assign ovf_new  = ovf_q || !fits;
	assign k_x      = KW'(item.rank);
	assign n_k      = KW'(n_new);
	assign rank_bad = (item.rank == '0) || (k_x > n_k);
	assign hn       = hsel_q ? ccount_q : cnt_q;
	assign lx       = IW'({si_q, 1'b1});
	assign rx       = lx + IW'(1);
	assign plx      = IW'({pt_q, 1'b1});
	assign prx      = plx + IW'(1);
	assign hn_x     = IW'(hn);
	assign n_x      = IW'(cnt_q);
	assign hrd      = hsel_q ? c_rd : {s_rd, {AW{1'b0}}};
	assign bi_m1    = AW'(bi_q - CW'(1));
	assign cc_m1    = AW'(ccount_q - CW'(1));
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || result.ready);

	// shared compare unit: does a go before b in the current heap order
	always_comb begin
		cmp_a = hrd[CDW-1:AW];
		cmp_b = bv_q[CDW-1:AW];
		if (state_q == S_SDL) begin
			cmp_b = t_q[CDW-1:AW];
		end else if (state_q == S_INCMP) begin
			cmp_a = ins_q[CDW-1:AW];
			cmp_b = c_rd[CDW-1:AW];
		end
		gf = mode_q ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
	end

	// RAM control
	logic           h_we;
	logic [AW-1:0]  h_wa, h_ra;
	logic [CDW-1:0] h_wd;

	always_comb begin
		h_we = 1'b0;
		h_wa = si_q;
		h_wd = t_q;
		h_ra = si_q;
		s_we = 1'b0;
		s_wa = cnt_q[AW-1:0];
		s_wd = item.value;
		s_ra = '0;
		c_we = 1'b0;
		c_wa = c_q;
		c_wd = ins_q;
		c_ra = '0;
		unique case (state_q)
			S_IDLE: begin
				s_we = fire && fits;
			end
			S_BLD: begin
				s_ra = bi_m1;
			end
			S_SDDOWN: begin
				h_ra = lx[AW-1:0];
			end
			S_SDL: begin
				h_ra = rx[AW-1:0];
			end
			S_SDMV: begin
				h_we = (best_q != si_q);
				h_wd = bv_q;
			end
			S_SDFIN: begin
				h_we = 1'b1;
			end
			S_INUP: begin
				c_we = (c_q == '0);
				c_ra = AW'((c_q - AW'(1)) >> 1);
			end
			S_INCMP: begin
				c_we = 1'b1;
				c_wd = gf ? c_rd : ins_q;
			end
			S_PTOP: begin
				c_ra = cc_m1;
			end
			S_PCH: begin
				s_ra = plx[AW-1:0];
			end
			S_PRIGHT: begin
				s_ra = prx[AW-1:0];
			end
			default: begin
			end
		endcase
		if (state_q == S_SDDOWN || state_q == S_SDL || state_q == S_SDMV
				|| state_q == S_SDFIN) begin
			if (hsel_q) begin
				c_we = h_we;
				c_wa = h_wa;
				c_wd = h_wd;
				c_ra = h_ra;
			end else begin
				s_we = h_we;
				s_wa = h_wa;
				s_wd = h_wd[CDW-1:AW];
				s_ra = h_ra;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cnt_q       <= '0;
			ccount_q    <= '0;
			ovf_q       <= 1'b0;
			mode_q      <= 1'b0;
			hsel_q      <= 1'b0;
			pops_q      <= '0;
			bi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						cnt_q <= n_new;
						ovf_q <= ovf_new;
						if (item.last) begin
							res_q <= '0;
							if (ovf_new) begin
								st_q    <= ST_OVF;
								state_q <= S_FIN;
							end else if (rank_bad) begin
								st_q    <= ST_RANK;
								state_q <= S_FIN;
							end else begin
								st_q    <= ST_OK;
								mode_q  <= !(k_x <= (n_k >> 1));
								pops_q  <= (k_x <= (n_k >> 1)) ? CW'(k_x - KW'(1))
									: CW'(n_k - k_x);
								bi_q    <= n_new >> 1;
								state_q <= S_BLD;
							end
						end
					end
				end
				S_BLD: begin
					if (bi_q == '0) begin
						state_q <= S_CINIT;
					end else begin
						bi_q    <= bi_q - CW'(1);
						si_q    <= bi_m1;
						hsel_q  <= 1'b0;
						ret_q   <= S_BLD;
						state_q <= S_SDLOAD;
					end
				end
				S_SDLOAD: begin
					t_q     <= {s_rd, {AW{1'b0}}};
					state_q <= S_SDDOWN;
				end
				S_SDDOWN: begin
					state_q <= (lx < hn_x) ? S_SDL : S_SDFIN;
				end
				S_SDL: begin
					if (gf) begin
						best_q <= lx[AW-1:0];
						bv_q   <= hrd;
					end else begin
						best_q <= si_q;
						bv_q   <= t_q;
					end
					state_q <= (rx < hn_x) ? S_SDR : S_SDMV;
				end
				S_SDR: begin
					if (gf) begin
						best_q <= rx[AW-1:0];
						bv_q   <= hrd;
					end
					state_q <= S_SDMV;
				end
				S_SDMV: begin
					if (best_q == si_q) begin
						state_q <= S_SDFIN;
					end else begin
						si_q    <= best_q;
						state_q <= S_SDDOWN;
					end
				end
				S_SDFIN: begin
					state_q <= ret_q;
				end
				S_CINIT: begin
					state_q <= S_CINS;
				end
				S_CINS: begin
					ins_q    <= {s_rd, {AW{1'b0}}};
					c_q      <= '0;
					ccount_q <= CW'(1);
					ret_q    <= S_PLOOP;
					state_q  <= S_INUP;
				end
				S_INUP: begin
					if (c_q == '0) begin
						state_q <= ret_q;
					end else begin
						pp_q    <= AW'((c_q - AW'(1)) >> 1);
						state_q <= S_INCMP;
					end
				end
				S_INCMP: begin
					if (gf) begin
						c_q     <= pp_q;
						state_q <= S_INUP;
					end else begin
						state_q <= ret_q;
					end
				end
				S_PLOOP: begin
					state_q <= (pops_q == '0) ? S_RES : S_PTOP;
				end
				S_PTOP: begin
					pt_q     <= c_rd[AW-1:0];
					ccount_q <= ccount_q - CW'(1);
					state_q  <= S_PLAST;
				end
				S_PLAST: begin
					t_q     <= c_rd;
					si_q    <= '0;
					hsel_q  <= 1'b1;
					ret_q   <= S_PCH;
					state_q <= S_SDDOWN;
				end
				S_PCH: begin
					state_q <= (plx < n_x) ? S_PINSL : S_PEND;
				end
				S_PINSL: begin
					ins_q    <= {s_rd, plx[AW-1:0]};
					c_q      <= ccount_q[AW-1:0];
					ccount_q <= ccount_q + CW'(1);
					ret_q    <= S_PRIGHT;
					state_q  <= S_INUP;
				end
				S_PRIGHT: begin
					state_q <= (prx < n_x) ? S_PINSR : S_PEND;
				end
				S_PINSR: begin
					ins_q    <= {s_rd, prx[AW-1:0]};
					c_q      <= ccount_q[AW-1:0];
					ccount_q <= ccount_q + CW'(1);
					ret_q    <= S_PEND;
					state_q  <= S_INUP;
				end
				S_PEND: begin
					pops_q  <= pops_q - CW'(1);
					state_q <= S_PLOOP;
				end
				S_RES: begin
					state_q <= S_RES2;
				end
				S_RES2: begin
					res_q   <= (ccount_q != '0) ? c_rd[CDW-1:AW] : '0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the previous result has been taken
					if (fin_go) begin
						out_kth_q   <= res_q;
						out_st_q    <= st_q;
						cnt_q       <= '0;
						ccount_q    <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item.ready       = (state_q == S_IDLE);
	assign result.valid     = out_valid_q;
	assign result.kth_value = out_kth_q;
	assign result.status    = out_st_q;

	`HKS_ASSERT_NOW(a_err_zero, result.valid && result.status != ST_OK, result.kth_value == '0, "nonzero status with nonzero value")
	`HKS_ASSERT_NEXT(a_last_busy, fire && item.last, !item.ready, "ready high after a last request")
	`HKS_ASSERT_NOW(a_cand_bound, state_q != S_IDLE && state_q != S_FIN, ccount_q <= cnt_q, "candidate heap larger than set")
endmodule

>>> tb/tb.sv
// Self-checking testbench for heap_kth_smallest_select_top.
// Depends on hks_pkg, hks_item_if, hks_result_if and the block itself.
// Sets are streamed in and each last request is checked against a sort-based k-th pick.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hks_pkg::*;

	localparam int STORE_DEPTH = 1024;

	typedef struct {
		value_t  kth_value;
		status_t status;
	} selection_t;

	logic clk;
	logic arst_n;

	hks_item_if   item ();
	hks_result_if result ();

	heap_kth_smallest_select_top #(.MAX_ITEMS(STORE_DEPTH)) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.result(result)
	);

	// state of the set being loaded, mirrored from accepted requests
	int         set_values[$];
	bit         set_overflow;
	selection_t expected_selections[$];

	int  mismatch_count;
	int  requests_sent;
	int  selections_checked;
	int  status_seen[3];
	bit  quiet;          // no gaps on either side while set
	int  hold_request;   // long receiver hold-off, picked up by the receiver process
	int  hold_left;
	int  stall_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	function automatic int gap_length();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// k-th smallest of the set by insertion sort
	function automatic value_t kth_smallest(input int vals[$], input int k);
		int sorted[$];
		int j;
		int v;
		sorted = vals;
		for (int i = 1; i < sorted.size(); i++) begin
			v = sorted[i];
			j = i - 1;
			while (j >= 0 && sorted[j] > v) begin
				sorted[j + 1] = sorted[j];
				j--;
			end
			sorted[j + 1] = v;
		end
		return value_t'(sorted[k - 1]);
	endfunction

	// update the mirrored set on an accepted request; close it on last
	task automatic track_request(input value_t v, input rank_t k, input logic is_last);
		selection_t sel;
		if (set_values.size() < STORE_DEPTH)
			set_values.push_back(int'(v));
		else
			set_overflow = 1'b1;
		if (is_last) begin
			sel.kth_value = '0;
			if (set_overflow)
				sel.status = ST_OVF;
			else if (k == 0 || int'(k) > set_values.size())
				sel.status = ST_RANK;
			else begin
				sel.status = ST_OK;
				sel.kth_value = kth_smallest(set_values, int'(k));
			end
			expected_selections.push_back(sel);
			set_values.delete();
			set_overflow = 1'b0;
		end
	endtask

	// offer one request and hold it until accepted; valid stays high for back-to-back
	task automatic send_request(input value_t v, input rank_t k, input logic is_last);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.value <= v;
		item.rank  <= k;
		item.last  <= is_last;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		requests_sent++;
		track_request(v, k, is_last);
	endtask

	function automatic value_t random_value();
		case ($urandom_range(0, 7))
			0: return value_t'(32'h8000_0000);
			1: return value_t'(32'h7fff_ffff);
			2: return value_t'($urandom_range(0, 6)) - value_t'(3);
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic send_set(input value_t vals[$], input rank_t k);
		for (int i = 0; i < vals.size(); i++)
			send_request(vals[i], (i == vals.size() - 1) ? k : rank_t'($urandom),
				i == vals.size() - 1);
	endtask

	task automatic send_random_set(input int n);
		value_t vals[$];
		rank_t  k;
		for (int i = 0; i < n; i++)
			vals.push_back(random_value());
		case ($urandom_range(0, 9))
			0: k = 0;
			1: k = rank_t'($urandom);
			2: k = rank_t'(n + 1);
			default: k = rank_t'($urandom_range(1, n));
		endcase
		send_set(vals, k);
	endtask

	// drop the offer and wait until every selection has been checked
	task automatic wait_drained();
		item.valid <= 1'b0;
		while (expected_selections.size() != 0)
			@(posedge clk);
	endtask

	// receiver: check each accepted result, then decide ready for the next cycle
	always @(posedge clk or negedge arst_n) begin
		selection_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold_left = 0;
			stall_left = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_selections.size() == 0)
					report_mismatch("result with no selection pending");
				else begin
					want = expected_selections.pop_front();
					selections_checked++;
					if (result.status <= ST_OVF)
						status_seen[result.status]++;
					if (result.status !== want.status)
						report_mismatch($sformatf("status %0d, wanted %0d",
							result.status, want.status));
					if (result.kth_value !== want.kth_value)
						report_mismatch($sformatf("kth_value %0d, wanted %0d",
							result.kth_value, want.kth_value));
				end
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
						: $urandom_range(1, 3);
			end
		end
	end

	task automatic test_directed();
		value_t vals[$];
		vals = '{value_t'(32'sd5)};
		send_set(vals, 1);
		vals = '{value_t'(32'h8000_0000), value_t'(32'h7fff_ffff), 0, -1};
		send_set(vals, 1);
		send_set(vals, 4);
		vals = '{7, -3, 7, 7, -3, 12};
		send_set(vals, 2);   // min-heap path with duplicates
		send_set(vals, 5);   // max-heap path
		send_set(vals, 0);   // zero rank
		send_set(vals, 7);   // rank above count
		vals = '{1, 2};
		send_set(vals, rank_t'(11'h7ff));
		wait_drained();
	endtask

	task automatic test_overflow();
		value_t vals[$];
		quiet = 1'b1;
		for (int i = 0; i < STORE_DEPTH + 2; i++)
			vals.push_back(random_value());
		send_set(vals, 1);
		quiet = 1'b0;
		wait_drained();
	endtask

	// hold the receiver off while sets keep coming so the block stalls its input
	task automatic test_backpressure();
		hold_request = 400;
		for (int s = 0; s < 4; s++)
			send_random_set($urandom_range(2, 6));
		wait_drained();
	endtask

	task automatic test_random();
		int start;
		int sent_results;
		start = requests_sent;
		sent_results = 0;
		while (requests_sent - start < 1150 - STORE_DEPTH - 60 || sent_results < 12) begin
			quiet = ($urandom_range(0, 9) == 0);
			send_random_set(($urandom_range(0, 19) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12));
			sent_results++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.value = '0;
		item.rank = '0;
		item.last = 1'b0;
		quiet = 1'b0;
		hold_request = 0;
		mismatch_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (100) @(posedge clk);
		$display("Covered %0d requests and %0d selections (ok %0d, bad rank %0d, overflow %0d),",
			requests_sent, selections_checked, status_seen[0], status_seen[1], status_seen[2]);
		$display("including a store filled past its depth and a long result hold-off.");
		if (mismatch_count == 0)
			$display("heap_kth_smallest_select_top test passed");
		else
			$display("heap_kth_smallest_select_top test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d selections outstanding", expected_selections.size());
		$display("heap_kth_smallest_select_top test failed");
		$finish;
	end
endmodule

>>> heap_kth_smallest_select_top.f
+incdir+hdl
hdl/hks_pkg.sv
hdl/hks_item_if.sv
hdl/hks_result_if.sv
hdl/hks_ram.sv
hdl/heap_kth_smallest_select_top.sv
tb/tb.sv
